// ===== rtl/core/ptac_pkg.sv =====
// Shared types and constants of the pixel to ARGB8888 converter.
package ptac_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_PIXEL_DEPTH  = 3'd0;
   localparam logic [2:0] REG_VISUAL_CLASS = 3'd1;
   localparam logic [2:0] REG_PALETTE_SIZE = 3'd2;
   localparam logic [2:0] REG_RED_BITS     = 3'd3;
   localparam logic [2:0] REG_GREEN_BITS   = 3'd4;
   localparam logic [2:0] REG_BLUE_BITS    = 3'd5;

   // Request kinds.
   localparam logic OP_CONVERT   = 1'b0;
   localparam logic OP_PAL_WRITE = 1'b1;

   // Visual classes.
   localparam logic [2:0] CLASS_PSEUDO_COLOR = 3'd3;
   localparam logic [2:0] CLASS_TRUE_COLOR   = 3'd4;
   localparam logic [2:0] CLASS_DIRECT_COLOR = 3'd5;

   // Conversion modes.
   localparam logic [3:0] MODE_UNSUP   = 4'd0;
   localparam logic [3:0] MODE_INDEXED = 4'd1;
   localparam logic [3:0] MODE_565     = 4'd2;
   localparam logic [3:0] MODE_BGR565  = 4'd3;
   localparam logic [3:0] MODE_X555    = 4'd4;
   localparam logic [3:0] MODE_RGB888  = 4'd5;
   localparam logic [3:0] MODE_BGR888  = 4'd6;
   localparam logic [3:0] MODE_RGBX    = 4'd7;
   localparam logic [3:0] MODE_BGRX    = 4'd8;
   localparam logic [3:0] MODE_666     = 4'd9;

   localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
   localparam logic [31:0] ARGB_BLACK   = 32'hff000000;

   // Reset values of the configuration.
   localparam logic [5:0]  RST_PIXEL_DEPTH  = 6'd32;
   localparam logic [2:0]  RST_VISUAL_CLASS = 3'd4;
   localparam logic [8:0]  RST_PALETTE_SIZE = 9'd0;
   localparam logic [31:0] RST_RED_BITS     = 32'h00ff0000;
   localparam logic [31:0] RST_GREEN_BITS   = 32'h0000ff00;
   localparam logic [31:0] RST_BLUE_BITS    = 32'h000000ff;

   typedef struct packed {
      logic [5:0]  pixel_depth;
      logic [2:0]  visual_class;
      logic [8:0]  palette_size;
      logic [31:0] red_bits;
      logic [31:0] green_bits;
      logic [31:0] blue_bits;
   } cfg_type;

endpackage

// ===== rtl/core/pixel_to_argb8888_converter_core.sv =====
// Top level of the pixel to ARGB8888 converter.
// A convert beat passes the input, stage 2 and output registers on its way to rsp_.
// Throughput: one beat per cycle unless stalled; palette writes take a slot, no response.
// Stages: input register, palette read and channel unpack, output register.
// A held response beat with rsp_tready low freezes all three stages; req_tready follows.
// Reset clears the valid bits and the configuration; palette contents stay undefined.
module pixel_to_argb8888_converter_core #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pixel[31:0], pal_index[39:32], pal_red[55:40], pal_green[71:56], pal_blue[87:72]
   input  logic [87:0] req_tdata,
   // operation[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // argb[31:0]
   output logic [31:0] rsp_tdata,
   // unsupported[0]
   output logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int AW = $clog2(PALETTE_DEPTH);
   localparam logic [8:0] DEPTH_W = 9'(PALETTE_DEPTH);

   ptac_pkg::cfg_type cfg_ff;
   logic [3:0]        mode;
   logic              adv;

   // Stage 1.
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_op_ff;
   logic [87:0] s1_data_ff;
   logic [3:0]  s1_mode_ff;
   logic        s1_hit_ff;

   // Stage 2.
   logic        s2_valid_ff, s2_valid_in;
   logic [3:0]  s2_mode_ff;
   logic        s2_hit_ff;
   logic [23:0] s2_rgb_ff, s2_rgb_in;
   logic [23:0] pal_rd;

   // Stage 3.
   logic        s3_valid_ff;
   logic [31:0] s3_argb_ff, s3_argb_in;
   logic        s3_unsup_ff, s3_unsup_in;

   logic        pal_wr_en;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_depth  <= ptac_pkg::RST_PIXEL_DEPTH;
         cfg_ff.visual_class <= ptac_pkg::RST_VISUAL_CLASS;
         cfg_ff.palette_size <= ptac_pkg::RST_PALETTE_SIZE;
         cfg_ff.red_bits     <= ptac_pkg::RST_RED_BITS;
         cfg_ff.green_bits   <= ptac_pkg::RST_GREEN_BITS;
         cfg_ff.blue_bits    <= ptac_pkg::RST_BLUE_BITS;
      end else if (csr_we) begin
         unique case (csr_addr)
            ptac_pkg::REG_PIXEL_DEPTH:  cfg_ff.pixel_depth  <= csr_wdata[5:0];
            ptac_pkg::REG_VISUAL_CLASS: cfg_ff.visual_class <= csr_wdata[2:0];
            ptac_pkg::REG_PALETTE_SIZE: cfg_ff.palette_size <= csr_wdata[8:0];
            ptac_pkg::REG_RED_BITS:     cfg_ff.red_bits     <= csr_wdata;
            ptac_pkg::REG_GREEN_BITS:   cfg_ff.green_bits   <= csr_wdata;
            ptac_pkg::REG_BLUE_BITS:    cfg_ff.blue_bits    <= csr_wdata;
            default: ;
         endcase
      end
   end

   ptac_fmt_decode #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_decode (
      .cfg  (cfg_ff),
      .mode (mode)
   );

   // The whole pipeline moves when the output register is empty or being drained.
   assign adv        = !s3_valid_ff || rsp_tready;
   assign req_tready = adv;

   assign s1_valid_in = req_tvalid;
   assign s2_valid_in = s1_valid_ff && s1_op_ff == ptac_pkg::OP_CONVERT;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage 1: capture the beat with its mode and the palette range check.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff   <= req_tuser;
         s1_data_ff <= req_tdata;
         s1_mode_ff <= mode;
         s1_hit_ff  <= {1'b0, req_tdata[7:0]} < cfg_ff.palette_size;
      end
   end

   // Stage 2: palette access and direct unpack.
   assign pal_wr_en = adv && s1_valid_ff && s1_op_ff == ptac_pkg::OP_PAL_WRITE &&
                      {1'b0, s1_data_ff[39:32]} < DEPTH_W;

   ptac_palette #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (s1_data_ff[32 +: AW]),
      .wr_data ({s1_data_ff[55:48], s1_data_ff[71:64], s1_data_ff[87:80]}),
      .rd_en   (adv),
      .rd_addr (s1_data_ff[AW-1:0]),
      .rd_data (pal_rd)
   );

   ptac_unpack u_unpack (
      .mode  (s1_mode_ff),
      .pixel (s1_data_ff[31:0]),
      .rgb   (s2_rgb_in)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_mode_ff <= s1_mode_ff;
         s2_hit_ff  <= s1_hit_ff;
         s2_rgb_ff  <= s2_rgb_in;
      end
   end

   // Stage 3: result select.
   always_comb begin
      s3_unsup_in = 1'b0;
      priority if (s2_mode_ff == ptac_pkg::MODE_UNSUP) begin
         s3_argb_in  = 32'd0;
         s3_unsup_in = 1'b1;
      end else if (s2_mode_ff == ptac_pkg::MODE_INDEXED) begin
         s3_argb_in = s2_hit_ff ? {ptac_pkg::ALPHA_OPAQUE, pal_rd} : ptac_pkg::ARGB_BLACK;
      end else begin
         s3_argb_in = {ptac_pkg::ALPHA_OPAQUE, s2_rgb_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_argb_ff  <= s3_argb_in;
         s3_unsup_ff <= s3_unsup_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = s3_argb_ff;
   assign rsp_tuser  = s3_unsup_ff;

`ifndef ASSERT_OFF
   a_unsup_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("unsupported response carries nonzero pixel");

   a_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[31:24] == ptac_pkg::ALPHA_OPAQUE)
      else $error("converted pixel is not opaque");

   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      adv && s1_valid_ff && s1_op_ff == ptac_pkg::OP_PAL_WRITE |=> !s2_valid_ff)
      else $error("palette write produced a response slot");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");
`endif

endmodule

// ===== rtl/core/ptac_fmt_decode.sv =====
// Format decoder: picks the conversion mode from the configuration.
module ptac_fmt_decode #(
   parameter int PALETTE_DEPTH = 256
) (
   input  ptac_pkg::cfg_type cfg,
   output logic [3:0]        mode
);

   localparam logic [8:0] DEPTH_W = 9'(PALETTE_DEPTH);

   logic indexed;
   logic direct;

   function automatic logic masks_are(input ptac_pkg::cfg_type c, input logic [31:0] r,
                                      input logic [31:0] g, input logic [31:0] b);
      return c.red_bits == r && c.green_bits == g && c.blue_bits == b;
   endfunction

   assign indexed = cfg.visual_class <= ptac_pkg::CLASS_PSEUDO_COLOR;
   assign direct  = cfg.visual_class == ptac_pkg::CLASS_TRUE_COLOR ||
                    cfg.visual_class == ptac_pkg::CLASS_DIRECT_COLOR;

   always_comb begin
      mode = ptac_pkg::MODE_UNSUP;
      if (indexed) begin
         if (cfg.pixel_depth == 6'd8 && cfg.palette_size != 9'd0 &&
             cfg.palette_size <= DEPTH_W) begin
            mode = ptac_pkg::MODE_INDEXED;
         end
      end else if (direct) begin
         if (cfg.pixel_depth == 6'd16) begin
            if (masks_are(cfg, 32'h0000f800, 32'h000007e0, 32'h0000001f)) begin
               mode = ptac_pkg::MODE_565;
            end else if (masks_are(cfg, 32'h0000001f, 32'h000007e0, 32'h0000f800)) begin
               mode = ptac_pkg::MODE_BGR565;
            end else if (masks_are(cfg, 32'h00007c00, 32'h000003e0, 32'h0000001f)) begin
               mode = ptac_pkg::MODE_X555;
            end
         end else if (cfg.pixel_depth == 6'd24 || cfg.pixel_depth == 6'd32) begin
            // The 24-bit layouts give the same result as their 32-bit twins.
            if (masks_are(cfg, 32'h00ff0000, 32'h0000ff00, 32'h000000ff)) begin
               mode = ptac_pkg::MODE_RGB888;
            end else if (masks_are(cfg, 32'h000000ff, 32'h0000ff00, 32'h00ff0000)) begin
               mode = ptac_pkg::MODE_BGR888;
            end else if (cfg.pixel_depth == 6'd32) begin
               if (masks_are(cfg, 32'hff000000, 32'h00ff0000, 32'h0000ff00)) begin
                  mode = ptac_pkg::MODE_RGBX;
               end else if (masks_are(cfg, 32'h0000ff00, 32'h00ff0000, 32'hff000000)) begin
                  mode = ptac_pkg::MODE_BGRX;
               end else if (masks_are(cfg, 32'h0003f000, 32'h00000fc0, 32'h0000003f)) begin
                  mode = ptac_pkg::MODE_666;
               end
            end
         end
      end
   end

endmodule

// ===== rtl/core/ptac_unpack.sv =====
// Channel unpacker: extracts and widens red, green and blue of a direct pixel.
module ptac_unpack (
   input  logic [3:0]  mode,
   input  logic [31:0] pixel,
   output logic [23:0] rgb
);

   logic [4:0] r5, b5, g5;
   logic [5:0] g6, r6, b6;

   assign r5 = pixel[15:11];
   assign g6 = pixel[10:5];
   assign b5 = pixel[4:0];
   assign g5 = pixel[9:5];
   assign r6 = pixel[17:12];
   assign b6 = pixel[5:0];

   always_comb begin
      rgb = pixel[23:0];
      unique case (mode)
         ptac_pkg::MODE_565:
            rgb = {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
         ptac_pkg::MODE_BGR565:
            rgb = {b5, b5[4:2], g6, g6[5:4], r5, r5[4:2]};
         ptac_pkg::MODE_X555:
            rgb = {pixel[14:10], pixel[14:12], g5, g5[4:2], b5, b5[4:2]};
         ptac_pkg::MODE_BGR888:
            rgb = {pixel[7:0], pixel[15:8], pixel[23:16]};
         ptac_pkg::MODE_RGBX:
            rgb = pixel[31:8];
         ptac_pkg::MODE_BGRX:
            rgb = {pixel[15:8], pixel[23:16], pixel[31:24]};
         ptac_pkg::MODE_666:
            rgb = {r6, r6[5:4], pixel[11:6], pixel[11:10], b6, b6[5:4]};
         default:
            rgb = pixel[23:0];
      endcase
   end

endmodule

// ===== rtl/core/ptac_palette.sv =====
// Palette memory: one write port and one registered read port.
module ptac_palette #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(PALETTE_DEPTH)-1:0] wr_addr,
   input  logic [23:0]                      wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(PALETTE_DEPTH)-1:0] rd_addr,
   output logic [23:0]                      rd_data
);

   logic [23:0] mem [PALETTE_DEPTH];
   logic [23:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
